// File: src/gf2_output_shift_solver_defines.svh
// Assertion macros used by the solver's top-level RTL.
`ifndef GF2_OUTPUT_SHIFT_SOLVER_DEFINES_SVH
`define GF2_OUTPUT_SHIFT_SOLVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GF2OS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GF2OS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/gf2os_pkg.sv
`default_nettype none

package gf2os_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int ROW_W     = 64;
  localparam int IDX_W     = $clog2(MAX_ROWS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int COL_W     = 6;
  localparam int RIDX_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;
  localparam int RCNT_W    = 7;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_SOLVE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT      = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;   // load beat accepted, write the row
    logic start;  // solve beat accepted, latch target
    logic step;   // read the current row and advance
    logic emit;   // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic none;     // configured row count is zero
    logic last;     // current row is the final active row
    logic out_free; // output register can take a result
  } dp_status_t;

  typedef struct packed {
    logic             has_pivot;
    logic [COL_W-1:0] pivot_column;
    logic [ROW_W-1:0] row_word;
  } row_entry_t;

  // Clamp the configured row count to the table depth.
  function automatic logic [CNT_W-1:0] sat_rows(input logic [RCNT_W-1:0] cnt);
    logic [CNT_W-1:0] res;
    if (RCNT_W'(cnt) > RCNT_W'(MAX_ROWS)) begin
      res = CNT_W'(MAX_ROWS);
    end else begin
      res = CNT_W'(cnt);
    end
    return res;
  endfunction

  // Ones in the low n bit positions.
  function automatic logic [ROW_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int i = 0; i < ROW_W; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: src/gf2os_ctrl.sv
`default_nettype none

module gf2os_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_func,
  output logic                       in_stall,
  input  wire gf2os_pkg::dp_status_t st,
  output gf2os_pkg::ctrl_cmd_t       cmd
);

  gf2os_pkg::state_t state_r, state_nxt;
  logic              idle;

  assign idle     = (state_r == gf2os_pkg::S_IDLE);
  assign in_stall = !idle;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      gf2os_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_func == gf2os_pkg::FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = st.none ? gf2os_pkg::S_DONE : gf2os_pkg::S_RUN;
          end
        end
      end
      gf2os_pkg::S_RUN: begin
        cmd.step = 1'b1;
        if (st.last) begin
          state_nxt = gf2os_pkg::S_DRAIN;
        end
      end
      gf2os_pkg::S_DRAIN: begin
        state_nxt = gf2os_pkg::S_DONE;
      end
      gf2os_pkg::S_DONE: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = gf2os_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gf2os_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gf2os_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/gf2os_dp.sv
`default_nettype none

module gf2os_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire gf2os_pkg::ctrl_cmd_t                cmd,
  output gf2os_pkg::dp_status_t                    st,
  input  wire logic                                cfg_we,
  input  wire logic [gf2os_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gf2os_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic [gf2os_pkg::RIDX_W-1:0]        in_row_index,
  input  wire logic [gf2os_pkg::ROW_W-1:0]         in_row_word,
  input  wire logic [gf2os_pkg::COL_W-1:0]         in_pivot_column,
  input  wire logic                                in_has_pivot,
  input  wire logic [gf2os_pkg::ROW_W-1:0]         in_observed_bits,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [gf2os_pkg::ROW_W-1:0]              out_pivot_mask,
  output logic                                     out_solvable
);

  // Configuration registers.
  logic [gf2os_pkg::ROW_W-1:0]  ref_bits_r;
  logic [gf2os_pkg::RCNT_W-1:0] row_count_r;

  // Solve working state.
  logic [gf2os_pkg::CNT_W-1:0]  n_r;
  logic [gf2os_pkg::IDX_W-1:0]  idx_r;
  logic [gf2os_pkg::ROW_W-1:0]  target_r;
  logic [gf2os_pkg::ROW_W-1:0]  mask_r;
  logic                         ok_r;
  logic                         eval_r;

  // Row store and its registered read port.
  gf2os_pkg::row_entry_t mem [gf2os_pkg::MAX_ROWS];
  gf2os_pkg::row_entry_t rd_data_r;
  gf2os_pkg::row_entry_t wr_data;
  logic                  wr_ok;

  logic [gf2os_pkg::CNT_W-1:0] n_sat;
  logic                        row_par;

  logic                        out_valid_r;
  logic [gf2os_pkg::ROW_W-1:0] out_pivot_mask_r;
  logic                        out_solvable_r;

  assign n_sat   = gf2os_pkg::sat_rows(row_count_r);
  assign wr_ok   = (gf2os_pkg::CNT_W'(in_row_index) < gf2os_pkg::CNT_W'(gf2os_pkg::MAX_ROWS));
  assign wr_data = '{has_pivot: in_has_pivot, pivot_column: in_pivot_column,
                     row_word: in_row_word};
  assign row_par = ^(target_r & rd_data_r.row_word);

  assign st.none     = (n_sat == '0);
  assign st.last     = ({1'b0, idx_r} == (n_r - gf2os_pkg::CNT_W'(1)));
  assign st.out_free = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_pivot_mask = out_pivot_mask_r;
  assign out_solvable   = out_solvable_r;

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      mem[in_row_index[gf2os_pkg::IDX_W-1:0]] <= wr_data;
    end
    if (cmd.step) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_bits_r  <= '0;
      row_count_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == gf2os_pkg::CFG_REFERENCE_BITS) begin
        ref_bits_r <= cfg_wdata;
      end else if (cfg_index == gf2os_pkg::CFG_ROW_COUNT) begin
        row_count_r <= cfg_wdata[gf2os_pkg::RCNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_r <= 1'b0;
      idx_r  <= '0;
      ok_r   <= 1'b1;
    end else begin
      eval_r <= cmd.step;
      if (cmd.start) begin
        idx_r <= '0;
        ok_r  <= 1'b1;
      end else begin
        if (cmd.step) begin
          idx_r <= idx_r + gf2os_pkg::IDX_W'(1);
        end
        if (eval_r && row_par && !rd_data_r.has_pivot) begin
          ok_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r      <= n_sat;
      target_r <= (in_observed_bits ^ ref_bits_r) & gf2os_pkg::low_mask(n_sat);
      mask_r   <= '0;
    end else if (eval_r && row_par && rd_data_r.has_pivot) begin
      mask_r <= mask_r | (gf2os_pkg::ROW_W'(1) << rd_data_r.pivot_column);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pivot_mask_r <= ok_r ? mask_r : '0;
      out_solvable_r   <= ok_r;
    end
  end

endmodule

`default_nettype wire

// File: src/gf2_output_shift_solver.sv
// Timing: a load takes effect at its acceptance edge. A solve reads its n active rows in
//   turn (none when n is zero) and registers its result once the output register is free.
// Throughput: one load beat per cycle while no solve is in progress; no new beat is taken
//   until a solve has handed on its result, as the row store has a single read port.
// Reset: synchronous, active low; clears the controller, both configuration registers and the
//   output valid. The row store is not cleared and needs no clearing pass.
`default_nettype none

`include "gf2_output_shift_solver_defines.svh"

module gf2_output_shift_solver (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration write port.
  input  wire logic                            cfg_we,
  input  wire logic [gf2os_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gf2os_pkg::CFG_W-1:0]     cfg_wdata,
  // Input channel.
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_func,
  input  wire logic [gf2os_pkg::RIDX_W-1:0]    in_row_index,
  input  wire logic [gf2os_pkg::ROW_W-1:0]     in_row_word,
  input  wire logic [gf2os_pkg::COL_W-1:0]     in_pivot_column,
  input  wire logic                            in_has_pivot,
  input  wire logic [gf2os_pkg::ROW_W-1:0]     in_observed_bits,
  // Result channel.
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [gf2os_pkg::ROW_W-1:0]          out_pivot_mask,
  output logic                                 out_solvable
);

  // The controller sequences each solve: it accepts a beat only when idle, then steps the
  // datapath through the active rows one per cycle, waits in its drain state for the last
  // registered row to be evaluated, and hands the result to the output register once free.
  // A load beat is written straight into the row store in the cycle it is accepted.
  gf2os_pkg::ctrl_cmd_t  cmd;
  gf2os_pkg::dp_status_t st;

  gf2os_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the configuration registers, the row store, the masked target, the
  // running shift mask and solvable flag, and the output register. Each row read is
  // registered; the following cycle the parity of target AND row word decides whether the
  // row sets its pivot bit or, lacking a pivot, marks the system unsolvable.
  gf2os_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_row_index     (in_row_index),
    .in_row_word      (in_row_word),
    .in_pivot_column  (in_pivot_column),
    .in_has_pivot     (in_has_pivot),
    .in_observed_bits (in_observed_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pivot_mask   (out_pivot_mask),
    .out_solvable     (out_solvable)
  );

  // A result must never overwrite one that is still waiting to be taken.
  `GF2OS_ASSERT_NOW(a_emit_no_overwrite, cmd.emit, !(out_valid && out_stall), "result overwritten")

  // While rows are being read the input side must be held off.
  `GF2OS_ASSERT_NOW(a_step_stalls_input, cmd.step, in_stall, "input accepted mid-solve")

  // A solve over at least one row starts reading the store on the next cycle.
  `GF2OS_ASSERT_NEXT(a_start_reads, cmd.start && !st.none, cmd.step, "solve did not start reading")

  // Loading and solving are never commanded together.
  `GF2OS_ASSERT_NOW(a_load_excl, cmd.load, !cmd.start && !cmd.step && !cmd.emit, "command clash")

endmodule

`default_nettype wire

// File: test/tb_top.sv
module tb_top;
  import gf2os_pkg::*;

  // Idle time after the last result before a register write or the final verdict.
  localparam int SETTLE_CYCLES  = 80;
  // Cycles without any beat on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;

  // Register slots beyond the two defined registers; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // One beat of the input channel, exactly as it is presented on the ports.
  typedef struct packed {
    logic              func;
    logic [RIDX_W-1:0] row_index;
    logic [ROW_W-1:0]  row_word;
    logic [COL_W-1:0]  pivot_column;
    logic              has_pivot;
    logic [ROW_W-1:0]  observed_bits;
  } solver_beat_t;

  // One beat of the result channel.
  typedef struct packed {
    logic [ROW_W-1:0] pivot_mask;
    logic             solvable;
  } shift_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic              in_func          = FUNC_LOAD;
  logic [RIDX_W-1:0] in_row_index     = '0;
  logic [ROW_W-1:0]  in_row_word      = '0;
  logic [COL_W-1:0]  in_pivot_column  = '0;
  logic              in_has_pivot     = 1'b0;
  logic [ROW_W-1:0]  in_observed_bits = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ROW_W-1:0]  out_pivot_mask;
  logic              out_solvable;

  // Our own copy of the block's state: both registers and the row store.
  logic [ROW_W-1:0]  ref_bits_q;
  logic [RCNT_W-1:0] row_cnt_q;
  row_entry_t        row_store [MAX_ROWS];

  // Beats waiting to be driven, and the solve results still owed by the block.
  solver_beat_t  pending_beats [$];
  shift_result_t owed_results [$];

  // Rows that the stimulus has loaded so far. A solve is only queued once every
  // active row has been written, since reading an unwritten row is undefined.
  bit gen_written [MAX_ROWS];

  solver_beat_t cur_beat;
  bit           beat_taken;
  int           burst_left;
  int           gap_left;
  bit           stall_state;
  int           stall_left;
  int           quiet_cycles;
  int           errors;

  gf2_output_shift_solver i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_row_index     (in_row_index),
    .in_row_word      (in_row_word),
    .in_pivot_column  (in_pivot_column),
    .in_has_pivot     (in_has_pivot),
    .in_observed_bits (in_observed_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pivot_mask   (out_pivot_mask),
    .out_solvable     (out_solvable)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Works out the result of a solve from our copy of the state. The target is
  // the observed bits against the reference, trimmed to the active rows; each
  // row whose word has odd parity with the target either sets its pivot column
  // or, lacking a pivot, makes the whole system unsolvable.
  function automatic shift_result_t solve_shift(input logic [ROW_W-1:0] observed);
    shift_result_t    res;
    logic [ROW_W-1:0] target;
    int               n;
    n = (int'(row_cnt_q) > MAX_ROWS) ? MAX_ROWS : int'(row_cnt_q);
    target = observed ^ ref_bits_q;
    if (n < ROW_W) begin
      target = target & ((64'd1 << n) - 64'd1);
    end
    res.pivot_mask = '0;
    res.solvable   = 1'b1;
    for (int r = 0; r < n; r++) begin
      if (^(target & row_store[r].row_word)) begin
        if (!row_store[r].has_pivot) begin
          res.solvable = 1'b0;
          break;
        end
        res.pivot_mask[row_store[r].pivot_column] = 1'b1;
      end
    end
    if (!res.solvable) begin
      res.pivot_mask = '0;
    end
    return res;
  endfunction

  // Queues a load beat. The solve-only field carries noise, which the block ignores.
  task automatic push_load(input logic [RIDX_W-1:0] idx, input logic [ROW_W-1:0] word,
                           input logic [COL_W-1:0] col, input logic has);
    solver_beat_t b;
    b.func          = FUNC_LOAD;
    b.row_index     = idx;
    b.row_word      = word;
    b.pivot_column  = col;
    b.has_pivot     = has;
    b.observed_bits = {$urandom, $urandom};
    gen_written[idx] = 1'b1;
    pending_beats.push_back(b);
  endtask

  // Queues a solve beat with random noise on all of the load fields.
  task automatic push_solve(input logic [ROW_W-1:0] observed);
    solver_beat_t b;
    b.func          = FUNC_SOLVE;
    b.row_index     = RIDX_W'($urandom);
    b.row_word      = {$urandom, $urandom};
    b.pivot_column  = COL_W'($urandom);
    b.has_pivot     = 1'($urandom);
    b.observed_bits = observed;
    pending_beats.push_back(b);
  endtask

  // Loads one row with random content. Pivotless rows are often all zero, as
  // they are in a genuine elimination, so that solvable systems stay common.
  task automatic push_row(input logic [RIDX_W-1:0] idx, input int nopiv_pct);
    logic [ROW_W-1:0] word;
    logic             has;
    has = ($urandom_range(0, 99) >= nopiv_pct);
    case ($urandom_range(0, 7))
      0:       word = '1;
      1:       word = 64'd1 << $urandom_range(0, 63);
      default: word = {$urandom, $urandom};
    endcase
    if (!has && $urandom_range(0, 1)) begin
      word = '0;
    end
    push_load(idx, word, COL_W'($urandom), has);
  endtask

  // Queues a mix of loads and solves under the current register settings.
  task automatic queue_mix(input int n_items, input int nopiv_pct);
    int active;
    active = (int'(row_cnt_q) > MAX_ROWS) ? MAX_ROWS : int'(row_cnt_q);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 45) begin
        // Fill in any active row that has never been loaded before solving.
        for (int r = 0; r < active; r++) begin
          if (!gen_written[r]) begin
            push_row(RIDX_W'(r), nopiv_pct);
          end
        end
        case ($urandom_range(0, 5))
          0:       push_solve(ref_bits_q);
          1:       push_solve(ref_bits_q ^ (64'd1 << $urandom_range(0, 63)));
          default: push_solve({$urandom, $urandom});
        endcase
      end else if (active > 0 && $urandom_range(0, 2) == 0) begin
        push_row(RIDX_W'($urandom_range(0, active - 1)), nopiv_pct);
      end else begin
        push_row(RIDX_W'($urandom), nopiv_pct);
      end
    end
  endtask

  // Writes one register and mirrors the write in our copy. Only called while
  // the block is idle, so the copy never changes under a beat in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_REFERENCE_BITS: ref_bits_q = data;
      CFG_ROW_COUNT:      row_cnt_q  = data[RCNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds the stimulus back until every queued beat has gone and every result has
  // come, then lets the block settle for the given number of cycles.
  task automatic wait_idle(input int settle);
    while (pending_beats.size() != 0 || in_valid || owed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (settle) @(posedge clk);
  endtask

  // Stimulus and phase control.
  initial begin
    logic [RCNT_W-1:0] phase_rows;
    logic [CFG_W-1:0]  cnt_word;
    logic [ROW_W-1:0]  phase_ref;
    int                nopiv;

    ref_bits_q = '0;
    row_cnt_q  = '0;
    errors     = 0;
    for (int r = 0; r < MAX_ROWS; r++) begin
      row_store[r]   = '0;
      gen_written[r] = 1'b0;
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. With no active rows nothing is read, so the result must be
    // an empty mask that is solvable, whatever the observed bits are.
    write_reg(CFG_REFERENCE_BITS, '1);
    write_reg(CFG_ROW_COUNT, '0);
    push_solve('0);
    push_solve('1);
    push_load(6'd0, '1, 6'd63, 1'b1);
    push_load(6'd63, '0, 6'd0, 1'b0);
    push_load(6'd1, 64'd1, 6'd0, 1'b1);
    push_load(6'd2, 64'd4, 6'd63, 1'b0);
    push_load(6'd62, '1, 6'd5, 1'b0);
    wait_idle(SETTLE_CYCLES);

    // Writes to the unused register slots must leave both registers untouched.
    write_reg(CFG_REFERENCE_BITS, '0);
    write_reg(CFG_ROW_COUNT, 64'd3);
    write_reg(CFG_SPARE_2, {$urandom, $urandom});
    write_reg(CFG_SPARE_3, '1);
    push_solve('0);
    push_solve(64'd1);       // two pivot rows fire: columns 63 and 0
    push_solve(64'd2);       // only row 0 fires
    push_solve(64'd4);       // the pivotless row fires: unsolvable
    push_solve('1);          // unsolvable, and the mask must read as zero
    push_solve(64'hFFFF_0000_0000_0001); // bits above the active rows are dropped
    wait_idle(SETTLE_CYCLES);

    write_reg(CFG_REFERENCE_BITS, '1);
    push_solve('1);
    push_solve(~64'd1);
    push_load(6'd2, '0, 6'd1, 1'b1);
    push_solve(~64'd4);

    // Random part: one phase per register setting, the extremes among them.
    // Each phase is split by a full drain so that the sender also waits on
    // the block at least once mid-phase.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       phase_rows = 7'd127;   // saturates at the table depth
        1, 8:    phase_rows = 7'd64;
        2:       phase_rows = 7'd65;
        3:       phase_rows = 7'd1;
        4:       phase_rows = 7'd0;
        5:       phase_rows = RCNT_W'($urandom_range(2, 62));
        6:       phase_rows = 7'd63;
        7:       phase_rows = RCNT_W'($urandom_range(2, 12));
        default: phase_rows = 7'd2;
      endcase
      case (p)
        0:       nopiv = 10;
        1:       nopiv = 0;
        8:       nopiv = 40;
        default: nopiv = $urandom_range(0, 20);
      endcase
      case ($urandom_range(0, 3))
        0:       phase_ref = '0;
        1:       phase_ref = '1;
        default: phase_ref = {$urandom, $urandom};
      endcase
      // Upper bits of the row count write are noise; only the low seven count.
      cnt_word = {$urandom, $urandom};
      cnt_word[RCNT_W-1:0] = phase_rows;

      wait_idle(SETTLE_CYCLES);
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_ROW_COUNT, cnt_word);
        write_reg(CFG_REFERENCE_BITS, phase_ref);
      end else begin
        write_reg(CFG_REFERENCE_BITS, phase_ref);
        write_reg(CFG_ROW_COUNT, cnt_word);
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, {$urandom, $urandom});
      end

      // One phase rebuilds the whole table with pivots everywhere, which gives
      // full-depth solves that are mostly solvable with rich masks.
      if (p == 1) begin
        for (int r = 0; r < MAX_ROWS; r++) begin
          push_row(RIDX_W'(r), 0);
        end
      end
      queue_mix(20, nopiv);
      wait_idle(0);
      queue_mix(20, nopiv);
    end

    wait_idle(SETTLE_CYCLES);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Sender: takes beats from the queue and presents them in bursts of random
  // length separated by random gaps. A beat is held until the monitor has seen
  // it accepted; valid is only ever assigned once per falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        cur_beat = pending_beats.pop_front();
        in_func          <= cur_beat.func;
        in_row_index     <= cur_beat.row_index;
        in_row_word      <= cur_beat.row_word;
        in_pivot_column  <= cur_beat.pivot_column;
        in_has_pivot     <= cur_beat.has_pivot;
        in_observed_bits <= cur_beat.observed_bits;
        in_valid         <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if (burst_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 4);
            default:    gap_left = $urandom_range(5, 30);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternates between runs of stalling and runs of taking results.
  // Most open runs are short, but some are long enough to leave no stall at all
  // across several solves.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_state = !stall_state;
      if (stall_state) begin
        stall_left = $urandom_range(1, 12);
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(20, 60);
      end else begin
        stall_left = $urandom_range(1, 6);
      end
    end
    out_stall <= stall_state;
  end

  // Monitor: every accepted input beat updates our copy of the table or, for a
  // solve, adds the expected result; every accepted result beat is checked
  // against the oldest expectation, field by field.
  always @(posedge clk) begin : beat_monitor
    shift_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("result beat with no solve outstanding: pivot_mask %h, solvable %b",
                 out_pivot_mask, out_solvable);
          errors++;
        end else begin
          want = owed_results.pop_front();
          if (out_pivot_mask !== want.pivot_mask) begin
            $error("pivot_mask: expected %h, got %h", want.pivot_mask, out_pivot_mask);
            errors++;
          end
          if (out_solvable !== want.solvable) begin
            $error("solvable: expected %b, got %b", want.solvable, out_solvable);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        beat_taken = 1'b1;
        if (in_func == FUNC_LOAD) begin
          row_store[in_row_index].row_word     = in_row_word;
          row_store[in_row_index].pivot_column = in_pivot_column;
          row_store[in_row_index].has_pivot    = in_has_pivot;
        end else begin
          owed_results.push_back(solve_shift(in_observed_bits));
        end
      end
    end
  end

  // Watchdog: a correct block never goes this long without a beat on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

// File: filelist.f
+incdir+src
src/gf2os_pkg.sv
src/gf2os_ctrl.sv
src/gf2os_dp.sv
src/gf2_output_shift_solver.sv
test/tb_top.sv
